// ===== sv/ile_pkg.sv =====
// Shared types and constants for the indexed list engine.
// Holds operation and status codes and the request and response beat structs.
// No dependencies.
package ile_pkg;

    localparam int ILE_CAPACITY   = 256;
    localparam int ILE_DATA_WIDTH = 32;

    typedef enum logic [2:0] {
        OP_APPEND     = 3'd0,
        OP_INSERT     = 3'd1,
        OP_GET        = 3'd2,
        OP_SET        = 3'd3,
        OP_REMOVE_AT  = 3'd4,
        OP_FIND       = 3'd5,
        OP_REMOVE_VAL = 3'd6,
        OP_CLEAR      = 3'd7
    } t_ile_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_ile_status;

    typedef struct packed {
        t_ile_op     operation;
        logic [8:0]  position_in;
        logic [31:0] item_value;
    } t_ile_req;

    typedef struct packed {
        t_ile_status status;
        logic [31:0] value_out;
        logic [7:0]  found_position;
        logic [8:0]  entry_count;
    } t_ile_rsp;

endpackage

// ===== sv/ile_mem.sv =====
// Entry storage for the indexed list engine: one write port, one read port.
// Read data is registered. Uses no package.
module ile_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ile_ctrl.sv =====
// Sequencer of the indexed list engine: decodes a request, walks the entry
// memory one address per cycle through a shared compare and index unit.
// Depends on ile_pkg.
module ile_ctrl import ile_pkg::*; #(
    parameter int CAPACITY   = ILE_CAPACITY,
    parameter int DATA_WIDTH = ILE_DATA_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  t_ile_req                    i_req,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output t_ile_rsp                    o_res,
    output logic                        o_mem_we,
    output logic [$clog2(CAPACITY)-1:0] o_mem_waddr,
    output logic [DATA_WIDTH-1:0]       o_mem_wdata,
    output logic                        o_mem_re,
    output logic [$clog2(CAPACITY)-1:0] o_mem_raddr,
    input  logic [DATA_WIDTH-1:0]       i_mem_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 9) ? CW : 9;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_MOVE,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    t_ile_op             r_op, n_op;
    logic [PW-1:0]       r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [CW-1:0]       r_ridx, n_ridx;
    logic [AW-1:0]       r_widx, n_widx;
    logic [CW-1:0]       r_left, n_left;
    logic                r_pend, n_pend;
    logic                r_up, n_up;
    t_ile_status         r_status, n_status;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic [AW-1:0]       r_where, n_where;

    logic [PW-1:0]         pos_x;
    logic [PW-1:0]         cnt_x;
    logic [DATA_WIDTH-1:0] v_in;
    logic                  full;
    logic                  hit;

    assign pos_x = PW'(i_req.position_in);
    assign cnt_x = PW'(r_cnt);
    assign v_in  = DATA_WIDTH'(i_req.item_value);
    assign full  = (r_cnt >= CAP_C);
    // The one comparator shared by every search step.
    assign hit   = (i_mem_rdata == r_val);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_op     = r_op;
        n_pos    = r_pos;
        n_val    = r_val;
        n_ridx   = r_ridx;
        n_widx   = r_widx;
        n_left   = r_left;
        n_pend   = r_pend;
        n_up     = r_up;
        n_status = r_status;
        n_value  = r_value;
        n_where  = r_where;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_widx;
        o_mem_wdata = r_val;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_ridx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op     = i_req.operation;
                    n_pos    = pos_x;
                    n_val    = v_in;
                    n_status = ST_OK;
                    n_value  = '0;
                    n_where  = '0;
                    n_pend   = 1'b0;
                    unique case (i_req.operation)
                        OP_APPEND: begin
                            n_state = S_DONE;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_cnt[AW-1:0];
                                o_mem_wdata = v_in;
                                n_cnt       = r_cnt + 1'b1;
                            end
                        end
                        OP_INSERT: begin
                            if (pos_x > cnt_x) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else if (full) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_up    = 1'b1;
                                n_ridx  = r_cnt - 1'b1;
                                n_left  = r_cnt - pos_x[CW-1:0];
                                n_state = S_MOVE;
                            end
                        end
                        OP_GET, OP_SET, OP_REMOVE_AT: begin
                            if (pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = pos_x[AW-1:0];
                                n_state     = S_READ;
                            end
                        end
                        OP_FIND, OP_REMOVE_VAL: begin
                            n_ridx  = '0;
                            n_left  = r_cnt;
                            n_state = S_SCAN;
                        end
                        OP_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_value = i_mem_rdata;
                n_state = S_DONE;
                if (r_op == OP_SET) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_pos[AW-1:0];
                    o_mem_wdata = r_val;
                end else if (r_op == OP_REMOVE_AT) begin
                    n_up    = 1'b0;
                    n_ridx  = r_pos[CW-1:0] + 1'b1;
                    n_left  = r_cnt - 1'b1 - r_pos[CW-1:0];
                    n_pend  = 1'b0;
                    n_state = S_MOVE;
                end
            end
            S_SCAN: begin
                if (r_pend && hit) begin
                    n_where = r_widx;
                    n_value = i_mem_rdata;
                    n_pend  = 1'b0;
                    if (r_op == OP_REMOVE_VAL) begin
                        n_up    = 1'b0;
                        n_ridx  = CW'(r_widx) + 1'b1;
                        n_left  = r_cnt - 1'b1 - CW'(r_widx);
                        n_state = S_MOVE;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_left != '0) begin
                    o_mem_re = 1'b1;
                    n_widx   = r_ridx[AW-1:0];
                    n_ridx   = r_ridx + 1'b1;
                    n_left   = r_left - 1'b1;
                    n_pend   = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_status = ST_MISSING;
                    n_state  = S_DONE;
                end
            end
            S_MOVE: begin
                // Each read entry is written one place up or down in the cycle after its read.
                if (r_pend) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_widx;
                    o_mem_wdata = i_mem_rdata;
                end
                if (r_left != '0) begin
                    o_mem_re = 1'b1;
                    n_widx   = r_up ? (r_ridx[AW-1:0] + 1'b1) : (r_ridx[AW-1:0] - 1'b1);
                    n_ridx   = r_up ? (r_ridx - 1'b1) : (r_ridx + 1'b1);
                    n_left   = r_left - 1'b1;
                    n_pend   = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_state = S_DONE;
                    if (r_up) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_pos[AW-1:0];
                        o_mem_wdata = r_val;
                        n_cnt       = r_cnt + 1'b1;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_ridx   <= n_ridx;
        r_widx   <= n_widx;
        r_left   <= n_left;
        r_up     <= n_up;
        r_status <= n_status;
        r_value  <= n_value;
        r_where  <= n_where;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status         = r_status;
        o_res.value_out      = 32'(r_value);
        o_res.found_position = 8'(r_where);
        o_res.entry_count    = 9'(r_cnt);
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_C)
        else $error("entry count exceeds capacity");

    a_waddr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (CW'(o_mem_waddr) < CAP_C))
        else $error("memory write beyond capacity");

    a_pend_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(o_mem_re))
        else $error("pending read data without a read issued");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status != ST_OK)) |->
            (o_res.value_out == 32'd0 && o_res.found_position == 8'd0))
        else $error("error result carries nonzero value or position");

endmodule

// ===== sv/indexed_list_engine_top.sv =====
// Top level of the indexed list engine: sequencer, entry memory and the
// response output register. Depends on ile_pkg, ile_ctrl and ile_mem.
//
//  Channel    Direction  Handshake           Payload
//  request    in         i_valid / o_ready   i_req (t_ile_req)
//  response   out        o_valid / i_ready   o_rsp (t_ile_rsp)
//
// A request beat is taken only while the sequencer is idle. Append, clear
// and out-of-range or full errors go straight to the result, get and set
// after one memory read. Find and remove value compare one entry per cycle
// through the single memory read port; insert and remove at move one entry
// per cycle; remove value pays both walks.
// Reset empties the list at once; entry contents need no clearing.
// A finished response waits in the output register, so a stalled consumer
// delays the sequencer only when a second response is ready behind it.
module indexed_list_engine_top import ile_pkg::*; #(
    parameter int CAPACITY   = ILE_CAPACITY,
    parameter int DATA_WIDTH = ILE_DATA_WIDTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_ile_req i_req,
    output logic     o_valid,
    input  logic     i_ready,
    output t_ile_rsp o_rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic                  res_valid;
    logic                  res_ready;
    t_ile_rsp              res;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic     r_out_valid;
    t_ile_rsp r_rsp;

    ile_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .o_req_ready (o_ready),
        .i_req       (i_req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    ile_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The output register takes a new response when it is empty or its beat
    // leaves in the same cycle.
    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_rsp <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule
